// File: hdl/tcit_pkg.sv
// Shared types, constants and helper functions of the three-channel interval timer.
package tcit_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int PRESCALE_DIV = 4;
   localparam int PHASE_W      = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;
   localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PRESCALE_DIV - 1);

   localparam int GATE_CHANNEL = 2;

   localparam int REQ_W = 16;
   localparam int RSP_W = 16;

   // BCD borrow corrections when a lower digit is zero.
   localparam logic [15:0] BCD_TOP        = 16'h9999;
   localparam logic [15:0] BCD_STEP_TENS  = 16'h0010 - 16'h0009;
   localparam logic [15:0] BCD_STEP_HUNS  = 16'h0100 - 16'h0099;
   localparam logic [15:0] BCD_STEP_THOUS = 16'h1000 - 16'h0999;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_GATE  = 2'd3
   } op_type;

   localparam logic [1:0] CONTROL_PORT = 2'd3;

   typedef enum logic [1:0] {
      ACC_LATCH = 2'd0,
      ACC_LOW   = 2'd1,
      ACC_HIGH  = 2'd2,
      ACC_WORD  = 2'd3
   } access_type;

   // Mode field of the control word.
   localparam logic [2:0] MODE_TERMINAL = 3'd0;
   localparam logic [2:0] MODE_ONE_SHOT = 3'd1;
   localparam logic [2:0] MODE_RATE     = 3'd2;
   localparam logic [2:0] MODE_RATE_ALT = 3'd6;

   typedef enum logic [7:0] {
      MS_STOP0    = 8'b0000_0001,
      MS_COUNT0   = 8'b0000_0010,
      MS_STOP1    = 8'b0000_0100,
      MS_START1   = 8'b0000_1000,
      MS_COUNT1   = 8'b0001_0000,
      MS_STOP2    = 8'b0010_0000,
      MS_GATELOW2 = 8'b0100_0000,
      MS_COUNT2   = 8'b1000_0000
   } mode_state_type;

   typedef struct packed {
      logic       gate_level;
      logic [7:0] data;
      logic [1:0] port;
      op_type     operation;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   typedef struct packed {
      logic       out_two;
      logic       out_one;
      logic       out_zero;
      logic [7:0] read_data;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   typedef struct packed {
      logic       clk_en;
      logic       rd_en;
      logic       wr_en;
      logic       ctl_en;
      logic       gate_en;
      logic [7:0] data;
      logic       gate_level;
   } chan_cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_level;
   } chan_out_type;

   typedef struct packed {
      logic [15:0]    count;
      logic [15:0]    latched;
      logic [15:0]    reload;
      logic [7:0]     low_hold;
      logic           bcd;
      access_type     access;
      logic           byte_ff;
      logic           gate_held;
      logic           out_level;
      logic           latch_full;
      mode_state_type mode_state;
      logic           load_pending;
   } chan_state_type;

   // One step down of the counter, binary or BCD.
   function automatic logic [15:0] step_down(input logic [15:0] v, input logic bcd);
      logic [15:0] r;
      if (!bcd) begin
         r = v - 16'd1;
      end else if (v == 16'd0) begin
         r = BCD_TOP;
      end else if (v[3:0] != 4'd0) begin
         r = v - 16'd1;
      end else if (v[7:4] != 4'd0) begin
         r = v - BCD_STEP_TENS;
      end else if (v[11:8] != 4'd0) begin
         r = v - BCD_STEP_HUNS;
      end else begin
         r = v - BCD_STEP_THOUS;
      end
      return r;
   endfunction

endpackage

// File: hdl/tcit_prescaler.sv
// Divider that turns CPU clock tick items into channel clock enables.
module tcit_prescaler (
   input  logic clock,
   input  logic reset,
   input  logic tick_en,
   output logic fire
);
   import tcit_pkg::*;

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;

   assign fire = tick_en && (phase_ff == LAST_PHASE);

   always_comb begin
      phase_in = phase_ff;
      if (tick_en) begin
         if (fire) begin
            phase_in = '0;
         end else begin
            phase_in = phase_ff + PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// File: hdl/tcit_channel.sv
// One counter channel: byte access, control word, gate and counting modes.
module tcit_channel (
   input  logic                   clock,
   input  logic                   reset,
   input  tcit_pkg::chan_cmd_type cmd,
   output tcit_pkg::chan_out_type rsp
);
   import tcit_pkg::*;

   chan_state_type state_ff;
   chan_state_type state_in;

   // Loading a new count arms the counter in mode 0 and mode 2.
   function automatic chan_state_type load_count(input chan_state_type s,
                                                 input logic [15:0] v);
      chan_state_type r;
      r = s;
      r.reload = v;
      if (s.mode_state == MS_STOP0 || s.mode_state == MS_COUNT0) begin
         r.mode_state   = MS_COUNT0;
         r.load_pending = 1'b1;
         r.out_level    = 1'b0;
      end else if (s.mode_state == MS_STOP2 || s.mode_state == MS_COUNT2) begin
         r.mode_state   = MS_COUNT2;
         r.load_pending = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      logic [15:0] next_count;
      logic [15:0] src;
      logic [2:0]  mode;
      logic [7:0]  rd;

      state_in   = state_ff;
      rd         = 8'd0;
      next_count = step_down(state_ff.count, state_ff.bcd);
      src        = state_ff.latch_full ? state_ff.latched : state_ff.count;
      mode       = cmd.data[3:1];

      if (cmd.clk_en) begin
         unique case (state_ff.mode_state)
            MS_COUNT0: begin
               if (state_ff.load_pending) begin
                  state_in.count        = state_ff.reload;
                  state_in.load_pending = 1'b0;
               end else if (state_ff.gate_held) begin
                  state_in.count = next_count;
                  if (next_count == 16'd0) begin
                     state_in.out_level = 1'b1;
                  end
               end
            end
            MS_START1: begin
               state_in.count      = state_ff.reload;
               state_in.out_level  = 1'b0;
               state_in.mode_state = MS_COUNT1;
            end
            MS_COUNT1: begin
               state_in.count = next_count;
               if (next_count == 16'd0) begin
                  state_in.out_level = 1'b1;
               end
            end
            MS_GATELOW2: begin
               if (state_ff.gate_held) begin
                  state_in.mode_state   = MS_COUNT2;
                  state_in.count        = state_ff.reload;
                  state_in.load_pending = 1'b0;
               end
            end
            MS_COUNT2: begin
               if (state_ff.load_pending) begin
                  state_in.count        = state_ff.reload;
                  state_in.load_pending = 1'b0;
               end else if (!state_ff.gate_held) begin
                  state_in.out_level  = 1'b1;
                  state_in.mode_state = MS_GATELOW2;
               end else if (state_ff.count == 16'd1) begin
                  state_in.out_level = 1'b1;
                  state_in.count     = state_ff.reload;
               end else begin
                  state_in.count = next_count;
                  if (next_count == 16'd1) begin
                     state_in.out_level = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.rd_en) begin
         case (state_ff.access)
            ACC_LOW: begin
               rd                  = src[7:0];
               state_in.latch_full = 1'b0;
            end
            ACC_HIGH: begin
               rd                  = src[15:8];
               state_in.latch_full = 1'b0;
            end
            ACC_WORD: begin
               if (state_ff.byte_ff) begin
                  rd               = src[7:0];
                  state_in.byte_ff = 1'b0;
               end else begin
                  rd                  = src[15:8];
                  state_in.byte_ff    = 1'b1;
                  state_in.latch_full = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.wr_en) begin
         case (state_ff.access)
            ACC_LOW: begin
               state_in = load_count(state_ff, {8'd0, cmd.data});
            end
            ACC_HIGH: begin
               state_in = load_count(state_ff, {cmd.data, 8'd0});
            end
            ACC_WORD: begin
               if (state_ff.byte_ff) begin
                  // Low byte of a word write halts counting until the high byte.
                  state_in.low_hold     = cmd.data;
                  state_in.byte_ff      = 1'b0;
                  state_in.load_pending = 1'b0;
                  if (state_ff.mode_state == MS_COUNT0) begin
                     state_in.mode_state = MS_STOP0;
                  end else if (state_ff.mode_state == MS_COUNT1) begin
                     state_in.mode_state = MS_STOP1;
                  end else if (state_ff.mode_state == MS_COUNT2) begin
                     state_in.mode_state = MS_STOP2;
                  end
                  if (state_ff.mode_state == MS_COUNT0 || state_ff.mode_state == MS_STOP0) begin
                     state_in.out_level = 1'b0;
                  end
               end else begin
                  state_in         = load_count(state_ff, {cmd.data, state_ff.low_hold});
                  state_in.byte_ff = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.ctl_en) begin
         if (access_type'(cmd.data[5:4]) == ACC_LATCH) begin
            if (!state_ff.latch_full) begin
               state_in.latched    = state_ff.count;
               state_in.latch_full = 1'b1;
            end
         end else begin
            state_in.bcd     = cmd.data[0];
            state_in.access  = access_type'(cmd.data[5:4]);
            state_in.byte_ff = 1'b1;
            if (mode == MODE_TERMINAL) begin
               state_in.mode_state   = MS_STOP0;
               state_in.out_level    = 1'b0;
               state_in.load_pending = 1'b0;
            end else if (mode == MODE_ONE_SHOT) begin
               state_in.mode_state   = MS_STOP1;
               state_in.out_level    = 1'b1;
               state_in.load_pending = 1'b0;
            end else if (mode == MODE_RATE || mode == MODE_RATE_ALT) begin
               state_in.mode_state   = MS_STOP2;
               state_in.out_level    = 1'b1;
               state_in.load_pending = 1'b0;
            end
         end
      end else if (cmd.gate_en) begin
         // A rising gate (re)triggers the one-shot.
         if ((state_ff.mode_state == MS_STOP1 || state_ff.mode_state == MS_START1 ||
              state_ff.mode_state == MS_COUNT1) && !state_ff.gate_held && cmd.gate_level) begin
            state_in.mode_state = MS_START1;
         end
         state_in.gate_held = cmd.gate_level;
      end

      rsp.read_data = rd;
      rsp.out_level = state_in.out_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.count        <= 16'd0;
         state_ff.latched      <= 16'd0;
         state_ff.reload       <= 16'd0;
         state_ff.low_hold     <= 8'd0;
         state_ff.bcd          <= 1'b0;
         state_ff.access       <= ACC_LATCH;
         state_ff.byte_ff      <= 1'b1;
         state_ff.gate_held    <= 1'b1;
         state_ff.out_level    <= 1'b0;
         state_ff.latch_full   <= 1'b0;
         state_ff.mode_state   <= MS_STOP0;
         state_ff.load_pending <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/three_channel_interval_timer_top.sv
// Top level of the three-channel interval timer: stream ports, pipeline and channels.
//
// The timer holds three 16-bit down counters behind four byte ports (ports 0 to 2
// address the channel counters, port 3 takes the control word). Every request item
// is one operation: a CPU clock tick, a port read, a port write or a new level on
// the channel 2 gate. A divide-by-PRESCALE_DIV prescaler turns ticks into channel
// clocks. Each request item produces exactly one response item carrying the byte
// read (zero for anything but a read of a channel port) and the three channel
// output levels as they stand after the item. An accepted item is held in an input
// register; when the output register is free or being emptied, the channel state is
// updated in a single pass of logic and the response is captured in the output
// register, from which it is presented. One item is accepted in every clock cycle as
// long as the response side keeps taking items; the rate is set by the single-pass
// read-modify-write of the channel state registers.
module three_channel_interval_timer_top (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // req_tdata, from bit 0: operation[1:0], port[3:2], data[11:4], gate_level[12],
   // zero padding[15:13].
   input  logic [tcit_pkg::REQ_W-1:0] req_tdata,
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // rsp_tdata, from bit 0: read_data[7:0], out_zero[8], out_one[9], out_two[10],
   // zero padding[15:11].
   output logic [tcit_pkg::RSP_W-1:0] rsp_tdata
);
   import tcit_pkg::*;

   // Input register.
   logic     in_valid_ff;
   logic     in_valid_in;
   item_type item_ff;
   item_type item_in;

   // Output register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;
   result_type rsp_data_in;

   logic advance;
   logic tick_fire;

   chan_cmd_type cmd   [NUM_CHANNELS];
   chan_out_type ch_out[NUM_CHANNELS];

   // The held item is processed whenever the output register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         item_in     = item_type'(req_tdata[ITEM_W-1:0]);
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   tcit_prescaler u_prescaler (
      .clock   (clock),
      .reset   (reset),
      .tick_en (advance && (item_ff.operation == OP_TICK)),
      .fire    (tick_fire)
   );

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      always_comb begin
         cmd[c].clk_en     = advance && (item_ff.operation == OP_TICK) && tick_fire;
         cmd[c].rd_en      = advance && (item_ff.operation == OP_READ) &&
                             (item_ff.port == 2'(c));
         cmd[c].wr_en      = advance && (item_ff.operation == OP_WRITE) &&
                             (item_ff.port == 2'(c));
         cmd[c].ctl_en     = advance && (item_ff.operation == OP_WRITE) &&
                             (item_ff.port == CONTROL_PORT) &&
                             (item_ff.data[7:6] == 2'(c));
         cmd[c].gate_en    = advance && (item_ff.operation == OP_GATE) &&
                             (c == GATE_CHANNEL);
         cmd[c].data       = item_ff.data;
         cmd[c].gate_level = item_ff.gate_level;
      end

      tcit_channel u_channel (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[c]),
         .rsp   (ch_out[c])
      );
   end

   // Only the addressed channel returns a nonzero byte; absent channels read as low.
   always_comb begin
      logic [7:0] rd;
      logic [2:0] levels;
      rd     = 8'd0;
      levels = 3'b000;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         rd        = rd | ch_out[c].read_data;
         levels[c] = ch_out[c].out_level;
      end
      rsp_data_in.read_data = rd;
      rsp_data_in.out_zero  = levels[0];
      rsp_data_in.out_one   = levels[1];
      rsp_data_in.out_two   = levels[2];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - RESULT_W)'(0), rsp_data_ff};

`ifndef SYNTHESIS
   // Every processed item leaves a response in the output register.
   a_advance_gives_response: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not produce a response");

   // Only a read operation may return a nonzero byte.
   a_read_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (advance && (item_ff.operation != OP_READ)) |=> (rsp_data_ff.read_data == 8'd0))
      else $error("nonzero read data for an operation that is not a read");

   // A held item that cannot move on stays unchanged in the input register.
   a_input_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("stalled request item was lost or changed");
`endif

endmodule

// File: bench/tb_three_channel_interval_timer_top.sv
// Self-checking testbench of the three-channel interval timer, with its own timer model and stimulus.
module tb_three_channel_interval_timer_top;
   import tcit_pkg::*;

   // A mode value that the timer does not support; it must leave mode and output alone.
   localparam logic [2:0] MODE_SQUARE      = 3'd3;
   localparam int         RANDOM_ITEMS     = 700;
   localparam int         PHASES           = 4;
   localparam int         SETTLE_CYCLES    = 8;
   localparam int         CYCLE_LIMIT      = 200_000;

   // The scoreboard keeps its own copy of every channel and of the prescaler. Each accepted
   // item is applied to that copy at once, and the response that the item must produce is
   // queued until the block hands it over.
   class timer_scoreboard;
      bit [15:0]      counter      [NUM_CHANNELS];
      bit [15:0]      snapshot     [NUM_CHANNELS];
      bit [15:0]      reload       [NUM_CHANNELS];
      bit [7:0]       low_hold     [NUM_CHANNELS];
      bit             bcd          [NUM_CHANNELS];
      access_type     access       [NUM_CHANNELS];
      bit             low_next     [NUM_CHANNELS];
      bit             gate         [NUM_CHANNELS];
      bit             level        [NUM_CHANNELS];
      bit             held         [NUM_CHANNELS];
      mode_state_type mstate       [NUM_CHANNELS];
      bit             pending_load [NUM_CHANNELS];
      int unsigned    prescale;
      result_type     awaited_responses [$];
      int             error_count;

      function new();
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            counter[c]      = '0;
            snapshot[c]     = '0;
            reload[c]       = '0;
            low_hold[c]     = '0;
            bcd[c]          = 1'b0;
            access[c]       = ACC_LATCH;
            low_next[c]     = 1'b1;
            gate[c]         = 1'b1;
            level[c]        = 1'b0;
            held[c]         = 1'b0;
            mstate[c]       = MS_STOP0;
            pending_load[c] = 1'b0;
         end
         prescale    = 0;
         error_count = 0;
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction

      // Decimal step down digit by digit; a borrow through all four digits gives 9999.
      function bit [15:0] bcd_decrement(bit [15:0] v);
         bit [15:0] r;
         r = v;
         for (int d = 0; d < 4; d++) begin
            if (r[4*d +: 4] != 4'd0) begin
               r[4*d +: 4] = r[4*d +: 4] - 4'd1;
               return r;
            end
            r[4*d +: 4] = 4'd9;
         end
         return r;
      endfunction

      function bit [15:0] count_down(int c);
         return bcd[c] ? bcd_decrement(counter[c]) : counter[c] - 16'd1;
      endfunction

      function void clock_channel(int c);
         case (mstate[c])
            MS_COUNT0: begin
               if (pending_load[c]) begin
                  counter[c]      = reload[c];
                  pending_load[c] = 1'b0;
               end else if (gate[c]) begin
                  counter[c] = count_down(c);
                  if (counter[c] == 16'd0) level[c] = 1'b1;
               end
            end
            MS_START1: begin
               counter[c] = reload[c];
               level[c]   = 1'b0;
               mstate[c]  = MS_COUNT1;
            end
            MS_COUNT1: begin
               counter[c] = count_down(c);
               if (counter[c] == 16'd0) level[c] = 1'b1;
            end
            MS_GATELOW2: begin
               if (gate[c]) begin
                  mstate[c]       = MS_COUNT2;
                  counter[c]      = reload[c];
                  pending_load[c] = 1'b0;
               end
            end
            MS_COUNT2: begin
               if (pending_load[c]) begin
                  counter[c]      = reload[c];
                  pending_load[c] = 1'b0;
               end else if (!gate[c]) begin
                  level[c]  = 1'b1;
                  mstate[c] = MS_GATELOW2;
               end else if (counter[c] == 16'd1) begin
                  level[c]   = 1'b1;
                  counter[c] = reload[c];
               end else begin
                  counter[c] = count_down(c);
                  if (counter[c] == 16'd1) level[c] = 1'b0;
               end
            end
            default: ;
         endcase
      endfunction

      function void load_count(int c, bit [15:0] v);
         reload[c] = v;
         if (mstate[c] == MS_STOP0 || mstate[c] == MS_COUNT0) begin
            mstate[c]       = MS_COUNT0;
            pending_load[c] = 1'b1;
            level[c]        = 1'b0;
         end else if (mstate[c] == MS_STOP2 || mstate[c] == MS_COUNT2) begin
            mstate[c]       = MS_COUNT2;
            pending_load[c] = 1'b1;
         end
      endfunction

      function bit [7:0] read_channel(int c);
         bit [15:0] src;
         bit [7:0]  r;
         src = held[c] ? snapshot[c] : counter[c];
         r   = '0;
         case (access[c])
            ACC_LOW: begin
               r       = src[7:0];
               held[c] = 1'b0;
            end
            ACC_HIGH: begin
               r       = src[15:8];
               held[c] = 1'b0;
            end
            ACC_WORD: begin
               if (low_next[c]) begin
                  r           = src[7:0];
                  low_next[c] = 1'b0;
               end else begin
                  r           = src[15:8];
                  low_next[c] = 1'b1;
                  held[c]     = 1'b0;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void write_channel(int c, bit [7:0] d);
         case (access[c])
            ACC_LOW:  load_count(c, {8'h00, d});
            ACC_HIGH: load_count(c, {d, 8'h00});
            ACC_WORD: begin
               if (low_next[c]) begin
                  // The low byte alone halts a running count until the high byte follows.
                  low_hold[c]     = d;
                  low_next[c]     = 1'b0;
                  pending_load[c] = 1'b0;
                  case (mstate[c])
                     MS_COUNT0: mstate[c] = MS_STOP0;
                     MS_COUNT1: mstate[c] = MS_STOP1;
                     MS_COUNT2: mstate[c] = MS_STOP2;
                     default: ;
                  endcase
                  if (mstate[c] == MS_STOP0) level[c] = 1'b0;
               end else begin
                  load_count(c, {d, low_hold[c]});
                  low_next[c] = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void control(bit [7:0] d);
         int         c;
         access_type acc;
         bit [2:0]   m;
         c   = d[7:6];
         acc = access_type'(d[5:4]);
         m   = d[3:1];
         if (c >= NUM_CHANNELS) return;
         if (acc == ACC_LATCH) begin
            if (!held[c]) begin
               snapshot[c] = counter[c];
               held[c]     = 1'b1;
            end
            return;
         end
         bcd[c]      = d[0];
         access[c]   = acc;
         low_next[c] = 1'b1;
         if (m == MODE_RATE_ALT) m = MODE_RATE;
         case (m)
            MODE_TERMINAL: begin
               mstate[c] = MS_STOP0;
               level[c]  = 1'b0;
               pending_load[c] = 1'b0;
            end
            MODE_ONE_SHOT: begin
               mstate[c] = MS_STOP1;
               level[c]  = 1'b1;
               pending_load[c] = 1'b0;
            end
            MODE_RATE: begin
               mstate[c] = MS_STOP2;
               level[c]  = 1'b1;
               pending_load[c] = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void set_gate(bit g);
         int c;
         c = GATE_CHANNEL;
         if (c >= NUM_CHANNELS) return;
         // A rising gate arms the one-shot from any of its states.
         if ((mstate[c] == MS_STOP1 || mstate[c] == MS_START1 || mstate[c] == MS_COUNT1)
             && !gate[c] && g)
            mstate[c] = MS_START1;
         gate[c] = g;
      endfunction

      function bit output_of(int c);
         return (c < NUM_CHANNELS) ? level[c] : 1'b0;
      endfunction

      function void note_request(item_type it);
         result_type want;
         bit [7:0]   rd;
         rd = '0;
         case (it.operation)
            OP_TICK: begin
               prescale++;
               if (prescale >= PRESCALE_DIV) begin
                  prescale = 0;
                  for (int c = 0; c < NUM_CHANNELS; c++) clock_channel(c);
               end
            end
            OP_READ: begin
               if (it.port < NUM_CHANNELS) rd = read_channel(it.port);
            end
            OP_WRITE: begin
               if (it.port == CONTROL_PORT) control(it.data);
               else if (it.port < NUM_CHANNELS) write_channel(it.port, it.data);
            end
            default: set_gate(it.gate_level);
         endcase
         want.read_data = rd;
         want.out_zero  = output_of(0);
         want.out_one   = output_of(1);
         want.out_two   = output_of(2);
         awaited_responses.push_back(want);
      endfunction

      function void report_field(string field, logic [7:0] want, logic [7:0] got);
         $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (awaited_responses.size() == 0) begin
            $display("%0t: response expected none, actual %0h", $time, got);
            error_count++;
            return;
         end
         want = awaited_responses.pop_front();
         if (got.read_data !== want.read_data)
            report_field("read_data", want.read_data, got.read_data);
         if (got.out_zero !== want.out_zero)
            report_field("out_zero", want.out_zero, got.out_zero);
         if (got.out_one !== want.out_one)
            report_field("out_one", want.out_one, got.out_one);
         if (got.out_two !== want.out_two)
            report_field("out_two", want.out_two, got.out_two);
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   timer_scoreboard  scoreboard = new();
   int unsigned      sender_idle_pct    = 0;
   int unsigned      receiver_stall_pct = 0;
   int               items_sent         = 0;
   int               cycles             = 0;

   three_channel_interval_timer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Both handshakes are observed in one process: the response is checked before the new
   // item is noted, so the outcome never hangs on the order of processes at an edge. All
   // signals read here were last changed by nonblocking assignments, so they hold the
   // values that the block saw at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            scoreboard.check_response(result_type'(rsp_tdata[RESULT_W-1:0]));
         if (req_tvalid && req_tready)
            scoreboard.note_request(item_type'(req_tdata[ITEM_W-1:0]));
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Presents one item, with random idle cycles ahead of it, and returns at the edge that
   // accepts it. Valid stays high into the next item when no idle cycle follows.
   task automatic send_item(input op_type op, input logic [1:0] port, input logic [7:0] data,
                            input logic gate_level);
      item_type it;
      it.operation  = op;
      it.port       = port;
      it.data       = data;
      it.gate_level = gate_level;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_W'(it);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Fields that an operation does not use carry random values, so that every bit moves.
   task automatic tick();
      send_item(OP_TICK, 2'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic read_port(input logic [1:0] port);
      send_item(OP_READ, port, 8'($urandom), 1'($urandom));
   endtask

   task automatic write_port(input logic [1:0] port, input logic [7:0] data);
      send_item(OP_WRITE, port, data, 1'($urandom));
   endtask

   task automatic gate_to(input logic level);
      send_item(OP_GATE, 2'($urandom), 8'($urandom), level);
   endtask

   function automatic logic [7:0] control_word(input logic [1:0] ch, input access_type acc,
                                               input logic [2:0] mode, input logic bcd);
      return {ch, acc, mode, bcd};
   endfunction

   // Lowers valid and holds off until every response still owed has been taken. The count
   // is looked at on the falling edge, well clear of the updates at the rising edge.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (scoreboard.outstanding() != 0);
      @(posedge clock);
   endtask

   task automatic run_directed();
      // Nothing is programmed yet: a read gives zero and a count write is dropped.
      read_port(2'd0);
      write_port(2'd0, 8'hFF);
      // Channel 0: terminal count with a count of one, low then high byte.
      write_port(CONTROL_PORT, control_word(2'd0, ACC_WORD, MODE_TERMINAL, 1'b0));
      write_port(2'd0, 8'h01);
      write_port(2'd0, 8'h00);
      // Channel 1: BCD rate generator loaded with zero, so it wraps to 9999.
      write_port(CONTROL_PORT, control_word(2'd1, ACC_LOW, MODE_RATE, 1'b1));
      write_port(2'd1, 8'h00);
      // Channel 2: one-shot with high byte only, armed by a rising gate.
      write_port(CONTROL_PORT, control_word(2'd2, ACC_HIGH, MODE_ONE_SHOT, 1'b0));
      write_port(2'd2, 8'h00);
      gate_to(1'b0);
      gate_to(1'b1);
      // Two channel clocks: the loads land, then channel 0 reaches zero.
      repeat (2 * PRESCALE_DIV) tick();
      // A second latch while one is held must be ignored; the word read frees the latch.
      write_port(CONTROL_PORT, control_word(2'd0, ACC_LATCH, MODE_TERMINAL, 1'b0));
      write_port(CONTROL_PORT, control_word(2'd0, ACC_LATCH, MODE_TERMINAL, 1'b0));
      read_port(2'd0);
      read_port(2'd0);
      // Select 3 is no channel; mode 6 behaves as mode 2; mode 3 changes access and BCD only.
      write_port(CONTROL_PORT, control_word(2'd3, ACC_WORD, MODE_RATE, 1'b1));
      write_port(CONTROL_PORT, control_word(2'd1, ACC_WORD, MODE_RATE_ALT, 1'b0));
      write_port(CONTROL_PORT, control_word(2'd0, ACC_WORD, MODE_SQUARE, 1'b1));
      write_port(2'd0, 8'hFF);
      write_port(2'd0, 8'hFF);
      read_port(CONTROL_PORT);
   endtask

   // One programmed channel followed by a run of mostly ticks, with reads, latches, gate
   // changes and reloads mixed in. Small counts let the channels reach terminal count.
   task automatic run_sequence();
      logic [1:0]  ch;
      access_type  acc;
      logic [2:0]  mode;
      logic [15:0] start;
      int          pick;
      ch  = 2'($urandom_range(NUM_CHANNELS - 1));
      acc = access_type'($urandom_range(3, 1));
      if ($urandom_range(9) < 7) begin
         case ($urandom_range(3))
            0:       mode = MODE_TERMINAL;
            1:       mode = MODE_ONE_SHOT;
            2:       mode = MODE_RATE;
            default: mode = MODE_RATE_ALT;
         endcase
      end else begin
         mode = 3'($urandom);
      end
      start = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(12, 1));
      write_port(CONTROL_PORT, control_word(ch, acc, mode, 1'($urandom)));
      case (acc)
         ACC_LOW:  write_port(ch, start[7:0]);
         ACC_HIGH: write_port(ch, 8'($urandom_range(1)));
         default: begin
            write_port(ch, start[7:0]);
            write_port(ch, start[15:8]);
         end
      endcase
      repeat ($urandom_range(40, 10)) begin
         pick = $urandom_range(99);
         if (pick < 60)
            tick();
         else if (pick < 72)
            read_port(ch);
         else if (pick < 78)
            write_port(CONTROL_PORT, control_word(ch, ACC_LATCH, 3'($urandom), 1'($urandom)));
         else if (pick < 90)
            gate_to(1'($urandom));
         else if (pick < 95)
            write_port(ch, 8'($urandom_range(15)));
         else
            read_port(2'($urandom));
      end
   endtask

   initial begin
      int first_random;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      first_random = items_sent;

      // Phases: no idling, a lazy sender, a stalling receiver, then a little of both.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase
         wait_until_drained();
         while (items_sent < first_random + (ph + 1) * RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(5, 1))
                  send_item(op_type'($urandom_range(3)), 2'($urandom), 8'($urandom),
                            1'($urandom));
            end else begin
               run_sequence();
            end
         end
      end

      receiver_stall_pct = 0;
      wait_until_drained();
      // Let any stray response show itself before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
hdl/tcit_pkg.sv
hdl/tcit_prescaler.sv
hdl/tcit_channel.sv
hdl/three_channel_interval_timer_top.sv
bench/tb_three_channel_interval_timer_top.sv
